FILE: hw/rtl/fnv1a_mixed_byte_hash_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mixed FNV-1a byte hash
// Clocked, reset-qualified assertion forms used by the top level.
// ----------------------------------------------------------------------------
`ifndef FNV1A_MIXED_BYTE_HASH_ASSERT_SVH
`define FNV1A_MIXED_BYTE_HASH_ASSERT_SVH

// same-cycle implication
`define FMBH_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FMBH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/fmbh_pkg.sv
// ----------------------------------------------------------------------------
// fmbh_pkg
// Types and constants shared by the mixed FNV-1a byte hash.
// ----------------------------------------------------------------------------
package fmbh_pkg;

    localparam int BYTE_W   = 8;
    localparam int HASH_W   = 32;
    localparam int DIGEST_W = 27;

    localparam logic [HASH_W-1:0] OFFSET_BASIS = 32'h811C_9DC5;
    localparam logic [HASH_W-1:0] FNV_PRIME    = 32'h0100_0193;

    localparam int SHIFT_A = 13;
    localparam int SHIFT_B = 7;
    localparam int SHIFT_C = 17;

    // 100000000 = 2^8 * 390625: low byte passes through, the rest is reduced
    localparam int LO_W    = 8;
    localparam int HI_W    = HASH_W - LO_W;
    localparam int REM_W   = 19;
    localparam int QUOT_W  = 6;
    localparam int RECIP_W = 14;
    localparam logic [HI_W-1:0]    MOD_HI = 24'd390625;
    localparam logic [RECIP_W-1:0] RECIP  = 14'd10995;   // floor(2^32 / 390625)
    localparam int RECIP_SH = 32;

    localparam logic [DIGEST_W-1:0] DIGEST_MOD = 27'd100000000;

    typedef struct packed {
        logic              valid;
        logic [HASH_W-1:0] value;
    } fin_t;

endpackage

FILE: hw/rtl/fmbh_if.sv
// ----------------------------------------------------------------------------
// fmbh interfaces
// Valid/ready channels for message bytes and digests.
// ----------------------------------------------------------------------------
interface fmbh_in_if;
    logic                        valid;
    logic                        ready;
    logic [fmbh_pkg::BYTE_W-1:0] msg_byte;
    logic                        is_last;

    modport source (output valid, output msg_byte, output is_last, input ready);
    modport sink   (input valid, input msg_byte, input is_last, output ready);
endinterface

interface fmbh_out_if;
    logic                          valid;
    logic                          ready;
    logic [fmbh_pkg::DIGEST_W-1:0] digest;

    modport source (output valid, output digest, input ready);
    modport sink   (input valid, input digest, output ready);
endinterface

FILE: hw/rtl/fmbh_mix.sv
// ----------------------------------------------------------------------------
// fmbh_mix
// Running hash register and per-byte mixing; captures the finished value.
// ----------------------------------------------------------------------------
module fmbh_mix (
    input  logic                  clk,
    input  logic                  rst_n,
    fmbh_in_if.sink               msg,
    input  logic                  fin_ready,
    output fmbh_pkg::fin_t        fin
);

    function automatic logic [fmbh_pkg::HASH_W-1:0] mix_byte(
        input logic [fmbh_pkg::HASH_W-1:0] h_in,
        input logic [fmbh_pkg::BYTE_W-1:0] b
    );
        logic [fmbh_pkg::HASH_W-1:0] h;
        h = h_in ^ {{(fmbh_pkg::HASH_W-fmbh_pkg::BYTE_W){1'b0}}, b};
        h = h * fmbh_pkg::FNV_PRIME;
        h = h + (h >> fmbh_pkg::SHIFT_A);
        h = h ^ (h << fmbh_pkg::SHIFT_B);
        h = h + (h >> fmbh_pkg::SHIFT_C);
        return h;
    endfunction

    logic [fmbh_pkg::HASH_W-1:0] hash_reg, hash_next;
    logic [fmbh_pkg::HASH_W-1:0] mixed;
    logic [fmbh_pkg::HASH_W-1:0] fin_val_reg, fin_val_next;
    logic                        fin_v_reg, fin_v_next;
    logic                        accept;

    assign msg.ready = !fin_v_reg || fin_ready;
    assign accept    = msg.valid && msg.ready;
    assign mixed     = mix_byte(hash_reg, msg.msg_byte);

    always_comb
    begin
        hash_next    = hash_reg;
        fin_val_next = fin_val_reg;
        fin_v_next   = fin_v_reg && !fin_ready;
        if (accept)
        begin
            hash_next = msg.is_last ? fmbh_pkg::OFFSET_BASIS : mixed;
            if (msg.is_last)
            begin
                fin_val_next = mixed;
                fin_v_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg  <= fmbh_pkg::OFFSET_BASIS;
            fin_v_reg <= 1'b0;
        end
        else
        begin
            hash_reg  <= hash_next;
            fin_v_reg <= fin_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fin_val_reg <= fin_val_next;
    end

    assign fin.valid = fin_v_reg;
    assign fin.value = fin_val_reg;

endmodule

FILE: hw/rtl/fmbh_mod.sv
// ----------------------------------------------------------------------------
// fmbh_mod
// Two-stage reduction of the finished hash modulo one hundred million.
// ----------------------------------------------------------------------------
module fmbh_mod (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fmbh_pkg::fin_t        fin,
    output logic                  fin_ready,
    fmbh_out_if.source            res
);

    localparam int PROD_W = fmbh_pkg::HI_W + fmbh_pkg::RECIP_W;

    // stage A: quotient estimate (exact or one short)
    logic                          a_v_reg, a_v_next;
    logic [fmbh_pkg::HI_W-1:0]     a_hi_reg, a_hi_next;
    logic [fmbh_pkg::LO_W-1:0]     a_lo_reg, a_lo_next;
    logic [fmbh_pkg::QUOT_W-1:0]   a_q_reg, a_q_next;
    logic [PROD_W-1:0]             prod;

    // output stage
    logic                          o_v_reg, o_v_next;
    logic [fmbh_pkg::DIGEST_W-1:0] o_dig_reg, o_dig_next;
    logic [fmbh_pkg::HI_W-1:0]     diff;
    logic [fmbh_pkg::REM_W-1:0]    rem;
    logic [fmbh_pkg::REM_W-1:0]    mod_hi_n;
    logic                          o_ready, a_ready;

    assign mod_hi_n  = fmbh_pkg::MOD_HI[fmbh_pkg::REM_W-1:0];
    assign o_ready   = !o_v_reg || res.ready;
    assign a_ready   = !a_v_reg || o_ready;
    assign fin_ready = a_ready;

    assign prod = PROD_W'(fin.value[fmbh_pkg::HASH_W-1:fmbh_pkg::LO_W])
                * PROD_W'(fmbh_pkg::RECIP);

    always_comb
    begin
        a_v_next  = a_v_reg && !o_ready;
        a_hi_next = a_hi_reg;
        a_lo_next = a_lo_reg;
        a_q_next  = a_q_reg;
        if (a_ready)
        begin
            a_v_next  = fin.valid;
            a_hi_next = fin.value[fmbh_pkg::HASH_W-1:fmbh_pkg::LO_W];
            a_lo_next = fin.value[fmbh_pkg::LO_W-1:0];
            a_q_next  = prod[fmbh_pkg::RECIP_SH +: fmbh_pkg::QUOT_W];
        end
    end

    always_comb
    begin
        diff = a_hi_reg - fmbh_pkg::HI_W'(a_q_reg) * fmbh_pkg::MOD_HI;
        rem  = diff[fmbh_pkg::REM_W-1:0];
        if (rem >= mod_hi_n)
        begin
            rem = rem - mod_hi_n;
        end
        o_v_next   = o_v_reg && !res.ready;
        o_dig_next = o_dig_reg;
        if (o_ready)
        begin
            o_v_next   = a_v_reg;
            o_dig_next = {rem, a_lo_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else
        begin
            a_v_reg <= a_v_next;
            o_v_reg <= o_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_hi_reg  <= a_hi_next;
        a_lo_reg  <= a_lo_next;
        a_q_reg   <= a_q_next;
        o_dig_reg <= o_dig_next;
    end

    assign res.valid  = o_v_reg;
    assign res.digest = o_dig_reg;

endmodule

FILE: hw/rtl/fnv1a_mixed_byte_hash.sv
// ----------------------------------------------------------------------------
// fnv1a_mixed_byte_hash
// Mixed FNV-1a hash of a byte stream; one digest per message.
// ----------------------------------------------------------------------------
//  channel | dir | payload                  | transaction
//  msg     | in  | msg_byte[7:0], is_last   | one message byte
//  res     | out | digest[26:0]             | one digest, per last byte
//
//  One byte per cycle while msg.ready is high: the running hash register feeds
//  back through the byte mix. The edge that accepts a last byte captures its hash;
//  stage A then forms the quotient estimate, and the output stage the remainder/output.
//  Reset loads the offset basis and empties the pipeline.
//  Stalls on res back up stage by stage; msg.ready drops only when all
//  three stages hold digests.
// ----------------------------------------------------------------------------
`include "fnv1a_mixed_byte_hash_assert.svh"

module fnv1a_mixed_byte_hash (
    input  logic        clk,
    input  logic        rst_n,
    fmbh_in_if.sink     msg,
    fmbh_out_if.source  res
);

    fmbh_pkg::fin_t fin;
    logic           fin_ready;

    fmbh_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg       (msg),
        .fin_ready (fin_ready),
        .fin       (fin)
    );

    fmbh_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .fin       (fin),
        .fin_ready (fin_ready),
        .res       (res)
    );

    `FMBH_ASSERT_SAME(a_digest_range, clk, rst_n, res.valid, res.digest < fmbh_pkg::DIGEST_MOD, "digest out of range")
    `FMBH_ASSERT_NEXT(a_last_captured, clk, rst_n, msg.valid && msg.ready && msg.is_last, fin.valid, "last byte not captured")
    `FMBH_ASSERT_NEXT(a_no_spurious, clk, rst_n, msg.valid && msg.ready && !msg.is_last && !fin.valid, !fin.valid, "digest from non-last byte")
    `FMBH_ASSERT_NEXT(a_fin_hold, clk, rst_n, fin.valid && !fin_ready, fin.valid && $stable(fin.value), "finished hash lost while stalled")

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for fnv1a_mixed_byte_hash
// A table of directed byte transactions is sent first, then about 400 random
// bytes grouped into messages. Every accepted byte updates a local model of
// the running hash. Each digest is checked in order against the queue of
// digests that the model expects. Both channels idle at random. Once, the
// digest side holds off for a long stretch so that the pipeline backs up
// into the byte channel.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [31:0] HASH_SEED    = 32'd2166136261;
    localparam logic [31:0] HASH_MULT    = 32'd16777619;
    localparam logic [31:0] DIGEST_RANGE = 32'd100000000;
    localparam int          MAX_GAP      = 18;
    localparam int          LONG_HOLD    = 90;
    localparam int          RANDOM_BYTES = 400;
    localparam int          DRAIN_CYCLES = 12;

    typedef struct {
        logic [fmbh_pkg::BYTE_W-1:0] msg_byte;
        logic                        is_last;
    } byte_row_t;

    logic clk;
    logic rst_n;

    fmbh_in_if  msg_ch ();
    fmbh_out_if res_ch ();

    fnv1a_mixed_byte_hash dut (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_ch),
        .res   (res_ch)
    );

    logic [31:0]                   message_hash = HASH_SEED;
    logic [fmbh_pkg::DIGEST_W-1:0] pending_digests [$];
    int unsigned                   error_count    = 0;
    int unsigned                   hold_requests  = 0;
    int unsigned                   holds_served   = 0;

    byte_row_t directed_rows [] = '{
        '{8'h00, 1'b1},
        '{8'hFF, 1'b1},
        '{8'h00, 1'b0},
        '{8'h00, 1'b0},
        '{8'h00, 1'b1},
        '{8'h55, 1'b0},
        '{8'hAA, 1'b1},
        '{8'h80, 1'b0},
        '{8'h01, 1'b0},
        '{8'h7F, 1'b0},
        '{8'hFE, 1'b1},
        '{8'h00, 1'b1},
        '{8'h00, 1'b1},
        '{8'hFF, 1'b0},
        '{8'hFF, 1'b0},
        '{8'hFF, 1'b0},
        '{8'hFF, 1'b1},
        '{8'h10, 1'b0},
        '{8'h20, 1'b0},
        '{8'h40, 1'b0},
        '{8'h08, 1'b0},
        '{8'h04, 1'b0},
        '{8'h02, 1'b1},
        '{8'hAA, 1'b1}
    };

    function automatic logic [31:0] mix_hash_byte(logic [31:0] h,
                                                   logic [fmbh_pkg::BYTE_W-1:0] b);
        logic [31:0] v;
        v = h ^ {24'd0, b};
        v = v * HASH_MULT;
        v = v + (v >> 13);
        v = v ^ (v << 7);
        v = v + (v >> 17);
        return v;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // model update and digest check, both on the rising edge
    always @(posedge clk)
    begin
        logic [31:0]                   sum;
        logic [fmbh_pkg::DIGEST_W-1:0] want;
        if (rst_n)
        begin
            if (msg_ch.valid === 1'b1 && msg_ch.ready === 1'b1)
            begin
                sum = mix_hash_byte(message_hash, msg_ch.msg_byte);
                if (msg_ch.is_last)
                begin
                    pending_digests.push_back(fmbh_pkg::DIGEST_W'(sum % DIGEST_RANGE));
                    message_hash = HASH_SEED;
                end
                else
                    message_hash = sum;
            end
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            begin
                if (pending_digests.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected digest transaction, actual %0d",
                             $time, res_ch.digest);
                end
                else
                begin
                    want = pending_digests.pop_front();
                    if (res_ch.digest !== want)
                    begin
                        error_count++;
                        $display("%0t: digest mismatch, expected %0d, actual %0d",
                                 $time, want, res_ch.digest);
                    end
                end
            end
        end
    end

    task automatic send_byte(input logic [fmbh_pkg::BYTE_W-1:0] b, input logic last,
                             input bit busy);
        int unsigned gap;
        gap = busy ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            msg_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        msg_ch.valid    <= 1'b1;
        msg_ch.msg_byte <= b;
        msg_ch.is_last  <= last;
        do
            @(posedge clk);
        while (msg_ch.ready !== 1'b1);
        @(negedge clk);
    endtask

    function automatic logic [fmbh_pkg::BYTE_W-1:0] draw_byte();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return fmbh_pkg::BYTE_W'($urandom);
        endcase
    endfunction

    // digest side: random hold-offs, plus the one long hold on request
    initial
    begin
        int unsigned gap;
        int unsigned served;
        bit          quiet;
        res_ch.ready = 1'b0;
        served = 0;
        quiet  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (served % 16 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (hold_requests != holds_served)
            begin
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                holds_served++;
            end
            else
            begin
                gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
                if (gap > 0)
                begin
                    res_ch.ready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (res_ch.valid !== 1'b1);
            served++;
        end
    end

    initial
    begin
        int unsigned sent;
        int unsigned msg_len;
        int unsigned pick;
        bit          busy;
        bit          pressed;
        msg_ch.valid    = 1'b0;
        msg_ch.msg_byte = '0;
        msg_ch.is_last  = 1'b0;
        rst_n           = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].msg_byte, directed_rows[i].is_last, 1'b0);

        sent    = 0;
        pressed = 1'b0;
        while (sent < RANDOM_BYTES)
        begin
            if (!pressed && sent >= RANDOM_BYTES / 2)
            begin
                // digests back up while single-byte messages keep arriving
                pressed = 1'b1;
                hold_requests++;
                for (int k = 0; k < 16; k++)
                    send_byte(draw_byte(), 1'b1, 1'b1);
                sent += 16;
            end
            pick = $urandom_range(0, 19);
            if (pick < 15)
                msg_len = $urandom_range(1, 8);
            else if (pick < 19)
                msg_len = $urandom_range(9, 32);
            else
                msg_len = $urandom_range(33, 64);
            busy = ($urandom_range(0, 3) == 0);
            for (int k = 1; k <= msg_len; k++)
                send_byte(draw_byte(), k == msg_len, busy);
            sent += msg_len;
        end
        msg_ch.valid <= 1'b0;

        while (pending_digests.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
